/* sv/mpm_pkg.sv */
// ============================================================================
// mpm_pkg: shared types and constants of the multiprecision multiplier
// Command and result structs, opcodes, sequencer states and default sizes.
// ============================================================================
package mpm_pkg;

    localparam int MPM_MAX_DIGITS = 256;
    localparam int MPM_DIGIT_BITS = 16;

    localparam logic [2:0] OP_CLEAR    = 3'd0;
    localparam logic [2:0] OP_APPEND_A = 3'd1;
    localparam logic [2:0] OP_APPEND_B = 3'd2;
    localparam logic [2:0] OP_MULTIPLY = 3'd3;
    localparam logic [2:0] OP_SQUARE   = 3'd4;
    localparam logic [2:0] OP_READ     = 3'd5;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] digit_value;
        logic [7:0]  read_index;
    } t_cmd;

    typedef struct packed {
        logic [15:0] product_digit;
        logic [8:0]  product_length;
        logic        overflow;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_RD,
        S_EX,
        S_CARRY,
        S_FIN
    } t_state;

endpackage

/* sv/mpm_mac.sv */
// ============================================================================
// mpm_mac: digit multiply-accumulate
// Forms x*y + w + c and splits it into a result digit and a carry digit.
// ============================================================================
module mpm_mac #(
    parameter int DIGIT_BITS = 16
) (
    input  logic [DIGIT_BITS-1:0] i_x,
    input  logic [DIGIT_BITS-1:0] i_y,
    input  logic [DIGIT_BITS-1:0] i_w,
    input  logic [DIGIT_BITS-1:0] i_c,
    output logic [DIGIT_BITS-1:0] o_lo,
    output logic [DIGIT_BITS-1:0] o_hi
);
    import mpm_pkg::*;

    logic [2*DIGIT_BITS-1:0] sum;

    // The sum never exceeds 2^(2*DIGIT_BITS)-1, so nothing is lost here.
    always_comb begin
        sum = (2*DIGIT_BITS)'(i_x) * (2*DIGIT_BITS)'(i_y)
            + (2*DIGIT_BITS)'(i_w) + (2*DIGIT_BITS)'(i_c);
    end

    assign o_lo = sum[DIGIT_BITS-1:0];
    assign o_hi = sum[2*DIGIT_BITS-1:DIGIT_BITS];

endmodule

/* sv/multiprecision_multiplier.sv */
// ============================================================================
// multiprecision_multiplier: schoolbook multiplier over digit memories
// Builds two operands digit by digit, multiplies or squares them, and serves
// product digits on request.
// ============================================================================
// A command is transferred when start is high and busy is low. Clear and the
// two appends give no result. A read gives its result in the cycle after
// its transfer, and reads may follow each other in every cycle.
// A multiply of an la-digit by an lb-digit operand (square: lb = la) keeps
// busy high until it is done, and its result comes in the same cycle as
// busy falls; with an empty operand the result follows at once and busy
// stays low. The product is built row by row in a working memory of
// 2*MAX_DIGITS digits, and every digit product has a read step for the
// operand and partial product digits, then an accumulate and write-back step.
// Each result is shown for exactly one cycle, marked by o_strobe, and is
// lost if the receiver does not take it then. No memory is cleared after
// reset.
module multiprecision_multiplier #(
    parameter int MAX_DIGITS = mpm_pkg::MPM_MAX_DIGITS,
    parameter int DIGIT_BITS = mpm_pkg::MPM_DIGIT_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  mpm_pkg::t_cmd    i_cmd,
    output logic             o_strobe,
    output mpm_pkg::t_result o_result
);
    import mpm_pkg::*;

    localparam int AW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int WAW = $clog2(2*MAX_DIGITS);
    localparam int LW  = $clog2(MAX_DIGITS + 1);
    localparam int FW  = $clog2(2*MAX_DIGITS + 1);
    localparam int CW  = (LW > 8) ? LW : 8;

    // Operand and working memories. The working memory doubles as the
    // product store: its low digits are the product after a multiply.
    logic [DIGIT_BITS-1:0] mem_a [MAX_DIGITS];
    logic [DIGIT_BITS-1:0] mem_b [MAX_DIGITS];
    logic [DIGIT_BITS-1:0] mem_w [2*MAX_DIGITS];
    logic [DIGIT_BITS-1:0] r_a_q, r_b_q, r_w_q;

    t_state r_state, n_state;

    logic [LW-1:0]         r_len_a, r_len_b, r_lx, r_ly, r_plen, r_low;
    logic [FW-1:0]         r_full;
    logic                  r_ovf, r_sq;
    logic [AW-1:0]         r_i, r_j;
    logic [DIGIT_BITS-1:0] r_ai, r_carry;
    logic                  r_strobe, r_rd_hit;

    logic                  accept;
    logic [AW-1:0]         a_raddr;
    logic [WAW-1:0]        w_raddr, w_waddr;
    logic [DIGIT_BITS-1:0] w_wdata;
    logic                  w_we, w_final;
    logic [DIGIT_BITS-1:0] mac_y, mac_w, mac_lo, mac_hi;
    logic                  last_j, last_i, rd_hit;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign last_j = (LW'(r_j) == r_ly - LW'(1));
    assign last_i = (LW'(r_i) == r_lx - LW'(1));
    assign rd_hit = (CW'(i_cmd.read_index) < CW'(r_plen));

    assign mac_y = r_sq ? r_a_q : r_b_q;
    // Row zero sees an all-zero partial product, so the memory needs no clear.
    assign mac_w = (r_i == '0) ? '0 : r_w_q;

    mpm_mac #(.DIGIT_BITS(DIGIT_BITS)) u_mac (
        .i_x (r_ai),
        .i_y (mac_y),
        .i_w (mac_w),
        .i_c (r_carry),
        .o_lo(mac_lo),
        .o_hi(mac_hi)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd.opcode == OP_MULTIPLY || i_cmd.opcode == OP_SQUARE)) begin
                    if (r_len_a != '0 &&
                        (i_cmd.opcode == OP_SQUARE || r_len_b != '0)) begin
                        n_state = S_ROW;
                    end
                end
            end
            S_ROW:   n_state = S_RD;
            S_RD:    n_state = S_EX;
            S_EX:    n_state = last_j ? S_CARRY : S_RD;
            S_CARRY: n_state = last_i ? S_FIN : S_ROW;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Memory addressing and write-back control.
    always_comb begin
        a_raddr = (r_state == S_ROW) ? r_i : r_j;
        w_raddr = (r_state == S_IDLE) ? WAW'(i_cmd.read_index)
                                      : WAW'(r_i) + WAW'(r_j);
        w_we    = 1'b0;
        w_waddr = WAW'(r_i) + WAW'(r_j);
        w_wdata = mac_lo;
        w_final = 1'b0;
        case (r_state)
            S_EX: begin
                w_we    = 1'b1;
                // A digit is settled when no later row reaches it.
                w_final = (r_j == '0) || last_i;
            end
            S_CARRY: begin
                w_we    = 1'b1;
                w_waddr = WAW'(r_i) + WAW'(r_ly);
                w_wdata = r_carry;
                w_final = last_i;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_cmd.opcode == OP_APPEND_A && r_len_a < LW'(MAX_DIGITS)) begin
            mem_a[AW'(r_len_a)] <= DIGIT_BITS'(i_cmd.digit_value);
        end
        r_a_q <= mem_a[a_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_cmd.opcode == OP_APPEND_B && r_len_b < LW'(MAX_DIGITS)) begin
            mem_b[AW'(r_len_b)] <= DIGIT_BITS'(i_cmd.digit_value);
        end
        r_b_q <= mem_b[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_w[w_waddr] <= w_wdata;
        end
        r_w_q <= mem_w[w_raddr];
    end

    // Control and sequencing registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len_a  <= '0;
            r_len_b  <= '0;
            r_plen   <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
            r_rd_hit <= 1'b0;
            r_lx     <= '0;
            r_ly     <= '0;
            r_sq     <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_full   <= '0;
            r_low    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_cmd.opcode)
                            OP_CLEAR: begin
                                r_len_a <= '0;
                                r_len_b <= '0;
                            end
                            OP_APPEND_A: begin
                                if (r_len_a < LW'(MAX_DIGITS)) begin
                                    r_len_a <= r_len_a + LW'(1);
                                end
                            end
                            OP_APPEND_B: begin
                                if (r_len_b < LW'(MAX_DIGITS)) begin
                                    r_len_b <= r_len_b + LW'(1);
                                end
                            end
                            OP_MULTIPLY, OP_SQUARE: begin
                                r_rd_hit <= 1'b0;
                                r_sq     <= (i_cmd.opcode == OP_SQUARE);
                                r_lx     <= r_len_a;
                                r_ly     <= (i_cmd.opcode == OP_SQUARE) ? r_len_a : r_len_b;
                                r_i      <= '0;
                                r_j      <= '0;
                                r_full   <= '0;
                                r_low    <= '0;
                                if (n_state == S_IDLE) begin
                                    // An empty operand gives a zero product.
                                    r_plen   <= '0;
                                    r_ovf    <= 1'b0;
                                    r_strobe <= 1'b1;
                                end
                            end
                            OP_READ: begin
                                r_rd_hit <= rd_hit;
                                r_strobe <= 1'b1;
                            end
                            default: begin
                                r_rd_hit <= r_rd_hit;
                            end
                        endcase
                    end
                end
                S_EX: begin
                    if (!last_j) begin
                        r_j <= r_j + AW'(1);
                    end
                end
                S_CARRY: begin
                    r_j <= '0;
                    if (!last_i) begin
                        r_i <= r_i + AW'(1);
                    end
                end
                S_FIN: begin
                    r_plen   <= r_low;
                    r_ovf    <= (r_full > FW'(MAX_DIGITS));
                    r_strobe <= 1'b1;
                end
                default: begin
                    r_j <= r_j;
                end
            endcase
            // Leading-zero tracking: settled digits arrive in rising order.
            if (w_we && w_final && w_wdata != '0) begin
                r_full <= FW'(w_waddr) + FW'(1);
                if (FW'(w_waddr) < FW'(MAX_DIGITS)) begin
                    r_low <= LW'(w_waddr) + LW'(1);
                end
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD && r_j == '0) begin
            r_ai <= r_a_q;
        end
        if (r_state == S_EX) begin
            r_carry <= mac_hi;
        end else if (r_state == S_CARRY || r_state == S_IDLE) begin
            r_carry <= '0;
        end
    end

    assign o_strobe                = r_strobe;
    assign o_result.product_digit  = r_rd_hit ? 16'(r_w_q) : 16'd0;
    assign o_result.product_length = 9'(r_plen);
    assign o_result.overflow       = r_ovf;

    // An accumulate step always follows its read step.
    a_ex_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EX) |-> ($past(r_state) == S_RD))
        else $error("accumulate step without a preceding read step");

    // A nonzero digit only comes out of a read transferred in the cycle before.
    a_digit_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.product_digit != 16'd0) |->
        $past(accept && i_cmd.opcode == OP_READ))
        else $error("product digit returned without a read");

    // The stored product never claims more digits than the store holds.
    a_plen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_plen <= LW'(MAX_DIGITS)) && (r_low <= LW'(MAX_DIGITS)))
        else $error("product length beyond store size");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for the multiprecision multiplier
// Loads operands digit by digit, multiplies and squares them, and reads back
// product digits. A behavioral model predicts every result, which is checked
// field by field against the strobed outputs, with random sender gaps.
// ============================================================================
module testbench;
    import mpm_pkg::*;

    localparam int IDLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_ITEMS = 150;

    typedef struct {
        t_cmd cmd;
        bit   drain;
    } t_pending;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_cmd    i_cmd = '0;
    logic    o_strobe;
    t_result o_result;

    multiprecision_multiplier dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Commands waiting to be driven, results predicted and results observed.
    t_pending cmd_queue[$];
    t_result  expected_results[$];
    t_result  observed_results[$];
    t_cmd     in_flight;
    int       gap_left = 0;
    int       burst_left = 0;
    int       mismatches = 0;
    int       idle_cycles = 0;

    // Shadow copy of the multiplier's state.
    bit [15:0] shadow_a[MPM_MAX_DIGITS];
    bit [15:0] shadow_b[MPM_MAX_DIGITS];
    bit [15:0] shadow_prod[MPM_MAX_DIGITS];
    int        shadow_len_a = 0;
    int        shadow_len_b = 0;
    int        shadow_prod_len = 0;
    bit        shadow_ovf = 1'b0;

    // Schoolbook product of x (lx digits) and y (ly digits) into the shadow
    // product store, truncated to MAX_DIGITS and stripped of leading zeros.
    task automatic form_product(input bit use_b, input int lx, input int ly);
        longint unsigned wide[2*MPM_MAX_DIGITS];
        longint unsigned carry;
        longint unsigned t;
        longint unsigned yd;
        int full;
        int keep;
        for (int k = 0; k < 2*MPM_MAX_DIGITS; k++) wide[k] = 0;
        for (int i = 0; i < lx; i++) begin
            carry = 0;
            for (int j = 0; j < ly; j++) begin
                yd = use_b ? shadow_b[j] : shadow_a[j];
                t = longint'(shadow_a[i]) * yd + wide[i+j] + carry;
                wide[i+j] = t & 64'hFFFF;
                carry = t >> 16;
            end
            wide[i+ly] = carry;
        end
        full = lx + ly;
        while (full > 0 && wide[full-1] == 0) full--;
        shadow_ovf = (full > MPM_MAX_DIGITS);
        keep = shadow_ovf ? MPM_MAX_DIGITS : full;
        for (int k = 0; k < MPM_MAX_DIGITS; k++)
            shadow_prod[k] = (k < keep) ? wide[k][15:0] : 16'h0;
        while (keep > 0 && shadow_prod[keep-1] == 0) keep--;
        shadow_prod_len = keep;
    endtask

    // Apply one transferred command to the shadow state and give its result.
    task automatic apply_command(input t_cmd c, output bit has, output t_result r);
        has = 1'b0;
        r = '0;
        case (c.opcode)
            OP_CLEAR: begin
                shadow_len_a = 0;
                shadow_len_b = 0;
            end
            OP_APPEND_A: begin
                if (shadow_len_a < MPM_MAX_DIGITS) begin
                    shadow_a[shadow_len_a] = c.digit_value;
                    shadow_len_a++;
                end
            end
            OP_APPEND_B: begin
                if (shadow_len_b < MPM_MAX_DIGITS) begin
                    shadow_b[shadow_len_b] = c.digit_value;
                    shadow_len_b++;
                end
            end
            OP_MULTIPLY: begin
                form_product(1'b1, shadow_len_a, shadow_len_b);
                has = 1'b1;
            end
            OP_SQUARE: begin
                form_product(1'b0, shadow_len_a, shadow_len_a);
                has = 1'b1;
            end
            OP_READ: begin
                if (int'(c.read_index) < shadow_prod_len)
                    r.product_digit = shadow_prod[c.read_index];
                has = 1'b1;
            end
            default: ;
        endcase
        if (has) begin
            r.product_length = shadow_prod_len[8:0];
            r.overflow = shadow_ovf;
        end
    endtask

    // Driver: one transfer per accepted cycle, in bursts separated by gaps.
    // A command marked drain waits until every predicted result has come.
    always @(posedge i_clk) begin
        bit       took;
        bit       has;
        t_result  r;
        t_pending next_item;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cmd <= '0;
        end else begin
            took = start && !busy;
            if (took) begin
                apply_command(in_flight, has, r);
                if (has) expected_results.push_back(r);
            end
            if (start && !took) begin
                // The block is still busy; keep the command on the bus.
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (cmd_queue.size() == 0 ||
                         (cmd_queue[0].drain && expected_results.size() != 0)) begin
                start <= 1'b0;
            end else begin
                next_item = cmd_queue.pop_front();
                in_flight = next_item.cmd;
                start <= 1'b1;
                i_cmd <= in_flight;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Monitor: the receiver takes every strobed result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) observed_results.push_back(o_result);
    end

    // Compare observed results with predictions in order, away from the edge.
    always @(negedge i_clk) begin
        t_result got;
        t_result want;
        while (observed_results.size() > 0) begin
            got = observed_results.pop_front();
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result digit=%h len=%0d ovf=%0d",
                             got.product_digit, got.product_length, got.overflow);
            end else begin
                want = expected_results.pop_front();
                if (got.product_digit !== want.product_digit ||
                    got.product_length !== want.product_length ||
                    got.overflow !== want.overflow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h/%0d/%0d got %h/%0d/%0d (digit/len/ovf)",
                                 want.product_digit, want.product_length, want.overflow,
                                 got.product_digit, got.product_length, got.overflow);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer or result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic push_cmd(input logic [2:0] op, input logic [15:0] dv,
                            input logic [7:0] idx, input bit drain);
        t_pending p;
        p.cmd.opcode = op;
        p.cmd.digit_value = dv;
        p.cmd.read_index = idx;
        p.drain = drain;
        cmd_queue.push_back(p);
    endtask

    // Random digit biased toward the extremes so carries get exercised.
    function automatic logic [15:0] pick_digit();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1, 2: return 16'hFFFF;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    int items;
    int la;
    int lb;

    initial begin
        // Directed part: reads, products and the two unused opcodes before anything is loaded.
        push_cmd(OP_READ, 16'h0, 8'd0, 1'b0);
        push_cmd(OP_READ, 16'hFFFF, 8'd255, 1'b0);
        push_cmd(OP_MULTIPLY, 16'h0, 8'h0, 1'b0);
        push_cmd(OP_SQUARE, 16'h0, 8'h0, 1'b0);
        push_cmd(3'd6, 16'hFFFF, 8'hFF, 1'b0);
        push_cmd(3'd7, 16'h1234, 8'h5A, 1'b0);
        // Small all-ones operands, then a leading zero digit on A.
        repeat (3) push_cmd(OP_APPEND_A, 16'hFFFF, 8'h0, 1'b0);
        repeat (2) push_cmd(OP_APPEND_B, 16'hFFFF, 8'h0, 1'b0);
        push_cmd(OP_MULTIPLY, 16'h0, 8'h0, 1'b0);
        for (int i = 0; i < 6; i++) push_cmd(OP_READ, 16'h0, i[7:0], 1'b0);
        push_cmd(OP_APPEND_A, 16'h0000, 8'h0, 1'b0);
        push_cmd(OP_SQUARE, 16'h0, 8'h0, 1'b0);
        push_cmd(OP_READ, 16'h0, 8'd5, 1'b0);
        // Clear keeps the product until the next multiply.
        push_cmd(OP_CLEAR, 16'h0, 8'h0, 1'b0);
        push_cmd(OP_READ, 16'h0, 8'd0, 1'b0);
        push_cmd(OP_MULTIPLY, 16'h0, 8'h0, 1'b0);
        // Full operand A, one extra digit ignored, its square overflows.
        repeat (MPM_MAX_DIGITS + 1)
            push_cmd(OP_APPEND_A, pick_digit() | 16'h8000, 8'h0, 1'b0);
        push_cmd(OP_SQUARE, 16'h0, 8'h0, 1'b0);
        push_cmd(OP_READ, 16'h0, 8'd0, 1'b0);
        push_cmd(OP_READ, 16'h0, 8'd255, 1'b0);
        push_cmd(OP_CLEAR, 16'h0, 8'h0, 1'b1);

        // Random part: mostly well-formed load/multiply/read sequences.
        items = 0;
        while (items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                push_cmd(3'($urandom_range(0, 7)), 16'($urandom_range(0, 16'hFFFF)),
                         8'($urandom_range(0, 255)), 1'b0);
                items++;
            end else begin
                push_cmd(OP_CLEAR, 16'h0, 8'h0, ($urandom_range(0, 15) == 0));
                case ($urandom_range(0, 19))
                    0: begin
                        la = $urandom_range(20, 48);
                        lb = $urandom_range(20, 48);
                    end
                    1: begin
                        la = 0;
                        lb = $urandom_range(0, 4);
                    end
                    default: begin
                        la = $urandom_range(1, 6);
                        lb = $urandom_range(0, 6);
                    end
                endcase
                for (int i = 0; i < la; i++) push_cmd(OP_APPEND_A, pick_digit(), 8'h0, 1'b0);
                for (int i = 0; i < lb; i++) push_cmd(OP_APPEND_B, pick_digit(), 8'h0, 1'b0);
                push_cmd(($urandom_range(0, 2) == 0) ? OP_SQUARE : OP_MULTIPLY,
                         16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)),
                         1'b0);
                items += la + lb + 2;
                repeat ($urandom_range(1, 4)) begin
                    push_cmd(OP_READ, 16'($urandom_range(0, 16'hFFFF)),
                             ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(0, la + lb + 1)),
                             1'b0);
                    items++;
                end
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every command is transferred and every result is in.
        do @(posedge i_clk);
        while (cmd_queue.size() != 0 || start || expected_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0 &&
            observed_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
